[rtl/synth_voice_allocator_unit_defines.svh]
// Assertion macros shared by the voice allocator RTL.
// No dependencies; files that assert include it by name.
`ifndef SYNTH_VOICE_ALLOCATOR_UNIT_DEFINES_SVH
`define SYNTH_VOICE_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SVALLOC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("voice allocator invariant violated");
`define SVALLOC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("voice allocator sequence violated");
`else
`define SVALLOC_ASSERT_ALWAYS(label, clk, rst, cond)
`define SVALLOC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/svalloc_pkg.sv]
// Types, codes and hash helpers for the voice allocator.
// No dependencies; used by synth_voice_allocator_unit.
package svalloc_pkg;

   typedef enum logic [2:0] {
      CMD_NOTE_ON       = 3'd0,
      CMD_NOTE_OFF      = 3'd1,
      CMD_ALL_NOTES_OFF = 3'd2,
      CMD_ALL_SOUND_OFF = 3'd3,
      CMD_RETIRE_VOICE  = 3'd4
   } cmd_type;

   localparam logic CSR_MODEL_LOADED = 1'b0;
   localparam logic CSR_MUTATION_ON  = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE       = 9'b000000001,
      ST_SCAN       = 9'b000000010,
      ST_DRAIN      = 9'b000000100,
      ST_COMMIT     = 9'b000001000,
      ST_HASH_GOLD  = 9'b000010000,
      ST_HASH_NOTE  = 9'b000100000,
      ST_HASH_VOICE = 9'b001000000,
      ST_HASH_DONE  = 9'b010000000,
      ST_SEND       = 9'b100000000
   } state_type;

   localparam logic [31:0] HASH_GOLDEN = 32'h9e3779b9;
   localparam logic [31:0] HASH_MIX    = 32'h7feb352d;
   localparam logic [3:0]  COUNT_MAX   = 4'd15;

   // Fold the upper half down before the mixing multiply.
   function automatic logic [31:0] hash_pre(input logic [31:0] x);
      return x ^ (x >> 16);
   endfunction

   // Final fold after the multiply; a zero hash is replaced by one.
   function automatic logic [31:0] hash_post(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x >> 15);
      return (y == 32'd0) ? 32'd1 : y;
   endfunction

endpackage

[rtl/synth_voice_allocator_unit.sv]
// Polyphonic voice allocator with oldest-voice stealing.
// Depends on svalloc_pkg and synth_voice_allocator_unit_defines.svh.
//
// Usage: commands enter on the req_ channel (valid/ready) and exactly one
// result item leaves on the rsp_ channel for every command. The csr_ port
// writes model_loaded (index 0) and mutation_on (index 1).
//
// Operation: the block takes one item at a time. Note-on and note-off walk
// the voice table one slot per cycle through a single read port of the
// note/age memory and a single age comparator, then pass the drain and
// commit states. An allocating note-on then runs the seed hash: three
// passes through the one shared 32x32 multiplier (hash gold, note and voice
// states) and a final fold (hash done state). Global commands, retire and
// ignored commands go straight from idle to the send state. Input ready
// returns in the cycle the result turns valid.
//
// Reset: all voices free, age counter zero, model_loaded 0, mutation_on 1.
// The note and age memory is not cleared; its contents are only used for active voices.
// A stalled receiver holds the result in the output register; the block
// keeps working on the next item and waits only to hand over a second one.
`include "synth_voice_allocator_unit_defines.svh"

module synth_voice_allocator_unit
   import svalloc_pkg::*;
#(
   parameter int VOICE_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Command channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [6:0]  req_note,
   input  logic [6:0]  req_velocity,
   input  logic [2:0]  req_retire_slot,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic [2:0]  rsp_slot,
   output logic        rsp_stole_active,
   output logic [31:0] rsp_noise_seed,
   output logic [15:0] rsp_variation_bits,
   output logic [3:0]  rsp_active_count,
   // Register write port
   input  logic        csr_wr_en,
   input  logic        csr_addr,
   input  logic        csr_wr_data
);

   localparam int IDX_W = $clog2(VOICE_COUNT);
   localparam int CNT_W = $clog2(VOICE_COUNT + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_COUNT - 1);

   // Control state
   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        scan_idx_ff, scan_idx_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    alloc_ff, alloc_in;
   logic                    steal_ff, steal_in;
   logic [6:0]              note_ff, note_in;
   logic                    found_ff, found_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic [31:0]             best_age_ff, best_age_in;
   logic                    best_rel_ff, best_rel_in;

   // Voice flags and counters
   logic [VOICE_COUNT-1:0]  active_ff, active_in;
   logic [VOICE_COUNT-1:0]  releasing_ff, releasing_in;
   logic [CNT_W-1:0]        active_cnt_ff, active_cnt_in;
   logic [31:0]             age_counter_ff, age_counter_in;

   // Hash datapath
   logic [31:0]             acc_ff, acc_in;
   logic [31:0]             nh_ff, nh_in;
   logic [31:0]             mul_a, mul_b, mul_p;

   // Pending result and output register
   logic                    res_accepted_ff, res_accepted_in;
   logic [2:0]              res_slot_ff, res_slot_in;
   logic                    res_stole_ff, res_stole_in;
   logic [31:0]             res_seed_ff, res_seed_in;
   logic [15:0]             res_var_ff, res_var_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_accepted_ff, rsp_accepted_in;
   logic [2:0]              rsp_slot_ff, rsp_slot_in;
   logic                    rsp_stole_ff, rsp_stole_in;
   logic [31:0]             rsp_seed_ff, rsp_seed_in;
   logic [15:0]             rsp_var_ff, rsp_var_in;
   logic [3:0]              rsp_count_ff, rsp_count_in;

   // Configuration registers
   logic                    model_loaded_ff, model_loaded_in;
   logic                    mutation_on_ff, mutation_on_in;

   // Note and age memory: one write port, one registered read port.
   logic [6:0]              note_mem [VOICE_COUNT];
   logic [31:0]             age_mem [VOICE_COUNT];
   logic [6:0]              rd_note_ff;
   logic [31:0]             rd_age_ff;
   logic                    mem_we;

   // Scan compare signals
   logic                    r_act, r_rel, age_less, eligible, better, take;
   logic [IDX_W-1:0]        retire_idx;
   logic [31:0]             age_inc, vh;

   assign mem_we  = (state_ff == ST_COMMIT) && alloc_ff;
   assign age_inc = age_counter_ff + 32'd1;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         note_mem[best_idx_ff] <= note_ff;
         age_mem[best_idx_ff]  <= age_inc;
      end
      rd_note_ff <= note_mem[scan_idx_ff];
      rd_age_ff  <= age_mem[scan_idx_ff];
   end

   // Shared multiplier; the sequencer picks its operands.
   always_comb begin
      case (state_ff)
         ST_HASH_GOLD:  mul_a = 32'(note_ff) + 32'd1;
         ST_HASH_VOICE: mul_a = hash_pre(hash_post(acc_ff) ^ age_counter_ff);
         default:       mul_a = hash_pre(acc_ff);
      endcase
      mul_b = (state_ff == ST_HASH_GOLD) ? HASH_GOLDEN : HASH_MIX;
   end
   assign mul_p = mul_a * mul_b;

   assign vh = hash_post(acc_ff);

   // One slot of the table is judged per cycle against the best so far.
   always_comb begin
      r_act    = active_ff[rd_idx_ff];
      r_rel    = releasing_ff[rd_idx_ff];
      age_less = rd_age_ff < best_age_ff;
      if (!alloc_ff) begin
         // Note-off: oldest held voice with a matching note.
         eligible = r_act && !r_rel && (rd_note_ff == note_ff);
         better   = !found_ff || age_less;
      end else if (!steal_ff) begin
         // Free slot exists: the lowest free one wins.
         eligible = !r_act;
         better   = !found_ff;
      end else begin
         // Steal: releasing beats held, then the oldest stamp.
         eligible = 1'b1;
         better   = !found_ff || (r_rel && !best_rel_ff) ||
                    ((r_rel == best_rel_ff) && age_less);
      end
      take = rd_valid_ff && eligible && better;
   end

   assign retire_idx = IDX_W'(req_retire_slot);

   always_comb begin
      state_in        = state_ff;
      scan_idx_in     = scan_idx_ff;
      rd_valid_in     = (state_ff == ST_SCAN);
      rd_idx_in       = scan_idx_ff;
      alloc_in        = alloc_ff;
      steal_in        = steal_ff;
      note_in         = note_ff;
      found_in        = found_ff;
      best_idx_in     = best_idx_ff;
      best_age_in     = best_age_ff;
      best_rel_in     = best_rel_ff;
      active_in       = active_ff;
      releasing_in    = releasing_ff;
      active_cnt_in   = active_cnt_ff;
      age_counter_in  = age_counter_ff;
      acc_in          = acc_ff;
      nh_in           = nh_ff;
      res_accepted_in = res_accepted_ff;
      res_slot_in     = res_slot_ff;
      res_stole_in    = res_stole_ff;
      res_seed_in     = res_seed_ff;
      res_var_in      = res_var_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_stole_in    = rsp_stole_ff;
      rsp_seed_in     = rsp_seed_ff;
      rsp_var_in      = rsp_var_ff;
      rsp_count_in    = rsp_count_ff;
      model_loaded_in = model_loaded_ff;
      mutation_on_in  = mutation_on_ff;

      if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_MODEL_LOADED: model_loaded_in = csr_wr_data;
            CSR_MUTATION_ON:  mutation_on_in  = csr_wr_data;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (take) begin
         found_in    = 1'b1;
         best_idx_in = rd_idx_ff;
         best_age_in = rd_age_ff;
         best_rel_in = r_rel;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               note_in         = req_note;
               found_in        = 1'b0;
               scan_idx_in     = '0;
               res_accepted_in = 1'b0;
               res_slot_in     = 3'd0;
               res_stole_in    = 1'b0;
               res_seed_in     = 32'd0;
               res_var_in      = 16'd0;
               state_in        = ST_SEND;
               unique case (req_command)
                  CMD_NOTE_ON: begin
                     if (model_loaded_ff) begin
                        // Zero velocity is treated as a note-off.
                        alloc_in = (req_velocity != 7'd0);
                        steal_in = &active_ff;
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_NOTE_OFF: begin
                     alloc_in = 1'b0;
                     state_in = ST_SCAN;
                  end
                  CMD_ALL_NOTES_OFF: begin
                     releasing_in    = releasing_ff | active_ff;
                     res_accepted_in = 1'b1;
                  end
                  CMD_ALL_SOUND_OFF: begin
                     active_in       = '0;
                     releasing_in    = '0;
                     active_cnt_in   = '0;
                     res_accepted_in = 1'b1;
                  end
                  CMD_RETIRE_VOICE: begin
                     if ((32'(req_retire_slot) < VOICE_COUNT) &&
                         active_ff[retire_idx] && releasing_ff[retire_idx]) begin
                        active_in[retire_idx]    = 1'b0;
                        releasing_in[retire_idx] = 1'b0;
                        active_cnt_in            = active_cnt_ff - CNT_W'(1);
                        res_accepted_in          = 1'b1;
                        res_slot_in              = req_retire_slot;
                     end
                  end
                  default: begin
                     res_accepted_in = 1'b0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            scan_idx_in = scan_idx_ff + IDX_W'(1);
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (alloc_ff) begin
               res_accepted_in           = 1'b1;
               res_slot_in               = 3'(best_idx_ff);
               res_stole_in              = active_ff[best_idx_ff];
               if (!active_ff[best_idx_ff]) begin
                  active_cnt_in = active_cnt_ff + CNT_W'(1);
               end
               active_in[best_idx_ff]    = 1'b1;
               releasing_in[best_idx_ff] = 1'b0;
               age_counter_in            = age_inc;
               state_in                  = ST_HASH_GOLD;
            end else begin
               if (found_ff) begin
                  releasing_in[best_idx_ff] = 1'b1;
                  res_accepted_in           = 1'b1;
                  res_slot_in               = 3'(best_idx_ff);
               end
               state_in = ST_SEND;
            end
         end
         ST_HASH_GOLD: begin
            acc_in   = mul_p;
            state_in = ST_HASH_NOTE;
         end
         ST_HASH_NOTE: begin
            acc_in   = mul_p;
            state_in = ST_HASH_VOICE;
         end
         ST_HASH_VOICE: begin
            nh_in    = hash_post(acc_ff);
            acc_in   = mul_p;
            state_in = ST_HASH_DONE;
         end
         ST_HASH_DONE: begin
            res_seed_in = mutation_on_ff ? vh : nh_ff;
            res_var_in  = vh[15:0];
            state_in    = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = res_accepted_ff;
               rsp_slot_in     = res_slot_ff;
               rsp_stole_in    = res_stole_ff;
               rsp_seed_in     = res_seed_ff;
               rsp_var_in      = res_var_ff;
               rsp_count_in    = (32'(active_cnt_ff) > 32'(COUNT_MAX)) ?
                                 COUNT_MAX : 4'(active_cnt_ff);
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rd_valid_ff     <= 1'b0;
         active_ff       <= '0;
         releasing_ff    <= '0;
         active_cnt_ff   <= '0;
         age_counter_ff  <= 32'd0;
         rsp_valid_ff    <= 1'b0;
         model_loaded_ff <= 1'b0;
         mutation_on_ff  <= 1'b1;
      end else begin
         state_ff        <= state_in;
         rd_valid_ff     <= rd_valid_in;
         active_ff       <= active_in;
         releasing_ff    <= releasing_in;
         active_cnt_ff   <= active_cnt_in;
         age_counter_ff  <= age_counter_in;
         rsp_valid_ff    <= rsp_valid_in;
         model_loaded_ff <= model_loaded_in;
         mutation_on_ff  <= mutation_on_in;
      end
      scan_idx_ff     <= scan_idx_in;
      rd_idx_ff       <= rd_idx_in;
      alloc_ff        <= alloc_in;
      steal_ff        <= steal_in;
      note_ff         <= note_in;
      found_ff        <= found_in;
      best_idx_ff     <= best_idx_in;
      best_age_ff     <= best_age_in;
      best_rel_ff     <= best_rel_in;
      acc_ff          <= acc_in;
      nh_ff           <= nh_in;
      res_accepted_ff <= res_accepted_in;
      res_slot_ff     <= res_slot_in;
      res_stole_ff    <= res_stole_in;
      res_seed_ff     <= res_seed_in;
      res_var_ff      <= res_var_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_stole_ff    <= rsp_stole_in;
      rsp_seed_ff     <= rsp_seed_in;
      rsp_var_ff      <= rsp_var_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_accepted_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_stole_active   = rsp_stole_ff;
   assign rsp_noise_seed     = rsp_seed_ff;
   assign rsp_variation_bits = rsp_var_ff;
   assign rsp_active_count   = rsp_count_ff;

   // A releasing voice is always an active one.
   `SVALLOC_ASSERT_ALWAYS(a_rel_in_active, clock, reset, (releasing_ff & ~active_ff) == '0)
   // The running voice count tracks the active flags.
   `SVALLOC_ASSERT_ALWAYS(a_count_match, clock, reset, $countones(active_ff) == 32'(active_cnt_ff))
   // An allocating note-on leaves its slot held and sounding.
   `SVALLOC_ASSERT_NEXT(a_alloc_held, clock, reset, mem_we, active_ff[best_idx_ff] && !releasing_ff[best_idx_ff])
   // The age counter only moves when a voice is stamped.
   `SVALLOC_ASSERT_NEXT(a_age_stable, clock, reset, !mem_we, $stable(age_counter_ff))

endmodule

[tb/synth_voice_allocator_unit_check.sv]
`timescale 1ns / 100ps
// Voice allocator checker: mirrors the voice table, predicts one result per command
// and compares it with what leaves the rsp_ channel. Depends on svalloc_pkg only.
module synth_voice_allocator_unit_check
   import svalloc_pkg::*;
#(
   parameter int VOICES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [6:0]  req_note,
   input  logic [6:0]  req_velocity,
   input  logic [2:0]  req_retire_slot,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_accepted,
   input  logic [2:0]  rsp_slot,
   input  logic        rsp_stole_active,
   input  logic [31:0] rsp_noise_seed,
   input  logic [15:0] rsp_variation_bits,
   input  logic [3:0]  rsp_active_count,
   input  logic        csr_wr_en,
   input  logic        csr_addr,
   input  logic        csr_wr_data,
   output int          fault_count,
   output int          results_pending
);

   localparam logic [31:0] GOLDEN_STEP = 32'h9e3779b9;
   localparam logic [31:0] MIX_FACTOR  = 32'h7feb352d;

   typedef struct packed {
      logic        accepted;
      logic [2:0]  slot;
      logic        stole_active;
      logic [31:0] noise_seed;
      logic [15:0] variation_bits;
      logic [3:0]  active_count;
   } voice_result_type;

   logic          loaded_cfg;
   logic          mutation_cfg;
   logic          voice_on [VOICES];
   logic          voice_releasing [VOICES];
   logic [6:0]    voice_note [VOICES];
   logic [31:0]   voice_age [VOICES];
   logic [31:0]   age_ctr;
   voice_result_type awaited_results[$];

   function automatic logic [31:0] scramble(input logic [31:0] value);
      logic [31:0] x;
      x = value ^ (value >> 16);
      x = x * MIX_FACTOR;
      x = x ^ (x >> 15);
      return (x == 32'd0) ? 32'd1 : x;
   endfunction

   function automatic string describe(input voice_result_type r);
      return $sformatf("accepted=%0d slot=%0d stole=%0d seed=%h var=%h count=%0d",
                       r.accepted, r.slot, r.stole_active, r.noise_seed,
                       r.variation_bits, r.active_count);
   endfunction

   task automatic clear_voice(input int i);
      voice_on[i] = 1'b0;
      voice_releasing[i] = 1'b0;
      voice_note[i] = '0;
      voice_age[i] = '0;
   endtask

   function automatic logic [3:0] voices_sounding();
      int n;
      n = 0;
      for (int i = 0; i < VOICES; i++)
         if (voice_on[i]) n++;
      return (n > 15) ? 4'd15 : 4'(n);
   endfunction

   // Applies one command to the mirrored voice table and returns its result.
   task automatic predict_command(input logic [2:0] cmd, input logic [6:0] note,
                                  input logic [6:0] vel, input logic [2:0] rslot,
                                  output voice_result_type res);
      int found;
      int sel;
      logic [31:0] note_hash;
      logic [31:0] voice_hash;
      res = '0;
      if (cmd == CMD_NOTE_ON || cmd == CMD_NOTE_OFF) begin
         if (cmd == CMD_NOTE_OFF || (loaded_cfg && vel == 7'd0)) begin
            // Release the oldest held voice playing this note.
            found = -1;
            for (int i = 0; i < VOICES; i++) begin
               if (voice_on[i] && !voice_releasing[i] && voice_note[i] == note)
                  if (found < 0 || voice_age[i] < voice_age[found]) found = i;
            end
            if (found >= 0) begin
               voice_releasing[found] = 1'b1;
               res.accepted = 1'b1;
               res.slot = 3'(found);
            end
         end else if (loaded_cfg) begin
            sel = -1;
            for (int i = 0; i < VOICES; i++)
               if (!voice_on[i] && sel < 0) sel = i;
            if (sel < 0) begin
               // Table full: releasing voices go first, then the oldest stamp.
               sel = 0;
               for (int i = 1; i < VOICES; i++) begin
                  if ((voice_releasing[i] && !voice_releasing[sel]) ||
                      (voice_releasing[i] == voice_releasing[sel] &&
                       voice_age[i] < voice_age[sel]))
                     sel = i;
               end
            end
            res.stole_active = voice_on[sel];
            age_ctr = age_ctr + 32'd1;
            voice_on[sel] = 1'b1;
            voice_releasing[sel] = 1'b0;
            voice_note[sel] = note;
            voice_age[sel] = age_ctr;
            note_hash = scramble(({25'd0, note} + 32'd1) * GOLDEN_STEP);
            voice_hash = scramble(note_hash ^ age_ctr);
            res.noise_seed = mutation_cfg ? voice_hash : note_hash;
            res.variation_bits = voice_hash[15:0];
            res.accepted = 1'b1;
            res.slot = 3'(sel);
         end
      end else if (cmd == CMD_ALL_NOTES_OFF) begin
         for (int i = 0; i < VOICES; i++)
            if (voice_on[i]) voice_releasing[i] = 1'b1;
         res.accepted = 1'b1;
      end else if (cmd == CMD_ALL_SOUND_OFF) begin
         for (int i = 0; i < VOICES; i++)
            clear_voice(i);
         res.accepted = 1'b1;
      end else if (cmd == CMD_RETIRE_VOICE) begin
         if (int'(rslot) < VOICES && voice_on[rslot] && voice_releasing[rslot]) begin
            clear_voice(int'(rslot));
            res.accepted = 1'b1;
            res.slot = rslot;
         end
      end
      res.active_count = voices_sounding();
   endtask

   always @(posedge clock) begin : track
      voice_result_type predicted;
      voice_result_type seen;
      if (reset) begin
         loaded_cfg = 1'b0;
         mutation_cfg = 1'b1;
         for (int i = 0; i < VOICES; i++)
            clear_voice(i);
         age_ctr = '0;
         awaited_results.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_addr == CSR_MODEL_LOADED) loaded_cfg = csr_wr_data;
            else mutation_cfg = csr_wr_data;
         end
         if (rsp_valid && rsp_ready) begin
            seen.accepted = rsp_accepted;
            seen.slot = rsp_slot;
            seen.stole_active = rsp_stole_active;
            seen.noise_seed = rsp_noise_seed;
            seen.variation_bits = rsp_variation_bits;
            seen.active_count = rsp_active_count;
            if (awaited_results.size() == 0) begin
               if (fault_count < 10) $display("unexpected result item: %s", describe(seen));
               fault_count++;
            end else begin
               predicted = awaited_results.pop_front();
               if (seen !== predicted) begin
                  if (fault_count < 10)
                     $display("result mismatch: expected %s, got %s",
                              describe(predicted), describe(seen));
                  fault_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_command(req_command, req_note, req_velocity, req_retire_slot, predicted);
            awaited_results.push_back(predicted);
         end
      end
      results_pending = awaited_results.size();
   end

endmodule

[tb/synth_voice_allocator_unit_test.sv]
`timescale 1ns / 100ps
// Top of the voice allocator testbench: clock, reset, command stimulus and verdict.
// Depends on svalloc_pkg, synth_voice_allocator_unit and synth_voice_allocator_unit_check.
module synth_voice_allocator_unit_test
   import svalloc_pkg::*;
();

   localparam int VOICES = 8;
   // The limit leaves ample room for random stalls, two long hold-offs and
   // roughly 2000 items.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 250;
   localparam int DRAIN_CYCLES = 40;
   // Command codes the block does not know; they must be ignored.
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   // Most notes come from a narrow window so that note-offs find their voices.
   localparam int POOL_LO = 56;
   localparam int POOL_HI = 63;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_command;
   logic [6:0]  req_note;
   logic [6:0]  req_velocity;
   logic [2:0]  req_retire_slot;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_accepted;
   logic [2:0]  rsp_slot;
   logic        rsp_stole_active;
   logic [31:0] rsp_noise_seed;
   logic [15:0] rsp_variation_bits;
   logic [3:0]  rsp_active_count;
   logic        csr_wr_en;
   logic        csr_addr;
   logic        csr_wr_data;

   int fault_count;
   int results_pending;
   int cycle_count;
   // Set by the stimulus for a phase in which neither side idles.
   bit calm;
   // The stimulus asks for a receiver hold-off by bumping this counter; the
   // receiver process grants it and counts the stall itself.
   int holds_requested;
   int holds_granted;

   synth_voice_allocator_unit #(.VOICE_COUNT(VOICES)) uut (.*);

   synth_voice_allocator_unit_check #(.VOICES(VOICES)) voice_check (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Safety net: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result side. It stalls at random about 16 percent of the time, not at
   // all in a calm phase, and holds off completely while a requested stretch runs.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_granted != holds_requested) begin
            holds_granted++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = calm || ($urandom_range(0, 99) >= 16);
         end
      end
   end

   // Offers one item and returns at the falling edge after it was taken. Valid
   // stays high afterwards, so back-to-back items keep it asserted; the item
   // already taken is never offered twice because the next call or settle()
   // changes the inputs before the following rising edge.
   task automatic send_item(input logic [2:0] cmd, input logic [6:0] note,
                            input logic [6:0] vel, input logic [2:0] rslot);
      while (!calm && $urandom_range(0, 99) < 16) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_command = cmd;
      req_note = note;
      req_velocity = vel;
      req_retire_slot = rslot;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drops valid and waits until every predicted result has come back.
   task automatic settle();
      req_valid = 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic addr, input logic data);
      csr_wr_en = 1'b1;
      csr_addr = addr;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Mostly note-ons and note-offs on a narrow note window so that voices fill,
   // get stolen and are released; retires, global commands and unknown codes
   // are mixed in. Fields a command does not use still carry random values.
   task automatic send_random_item();
      int pick;
      logic [2:0] cmd;
      logic [6:0] note;
      logic [6:0] vel;
      pick = $urandom_range(0, 99);
      if (pick < 52) cmd = CMD_NOTE_ON;
      else if (pick < 74) cmd = CMD_NOTE_OFF;
      else if (pick < 88) cmd = CMD_RETIRE_VOICE;
      else if (pick < 92) cmd = CMD_ALL_NOTES_OFF;
      else if (pick < 94) cmd = CMD_ALL_SOUND_OFF;
      else cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      note = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(POOL_LO, POOL_HI))
                                          : 7'($urandom_range(0, 127));
      vel = ($urandom_range(0, 99) < 12) ? 7'd0 : 7'($urandom_range(1, 127));
      send_item(cmd, note, vel, 3'($urandom_range(0, VOICES - 1)));
   endtask

   // One random phase under one register setting. Halfway through it may ask
   // for a receiver hold-off (the sender keeps pushing, so the block backs up)
   // or pause the sender until everything has drained.
   task automatic run_phase(input logic loaded, input logic mutation, input int items,
                            input bit quiet, input bit hold_midway, input bit pause_midway);
      settle();
      write_register(CSR_MODEL_LOADED, loaded);
      write_register(CSR_MUTATION_ON, mutation);
      calm = quiet;
      for (int n = 0; n < items; n++) begin
         if (n == items / 2) begin
            if (hold_midway) holds_requested++;
            if (pause_midway) settle();
         end
         send_random_item();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_NOTE_ON;
      req_note = '0;
      req_velocity = '0;
      req_retire_slot = '0;
      csr_wr_en = 1'b0;
      csr_addr = CSR_MODEL_LOADED;
      csr_wr_data = 1'b0;
      calm = 1'b0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // No model loaded yet: note-ons of any velocity are ignored, a note-off
      // finds nothing, a retire of a free slot and unknown codes do nothing,
      // while the global commands are still accepted.
      send_item(CMD_NOTE_ON, 7'd60, 7'd100, 3'd0);
      send_item(CMD_NOTE_ON, 7'd60, 7'd0, 3'd0);
      send_item(CMD_NOTE_OFF, 7'd60, 7'd0, 3'd0);
      send_item(CMD_RETIRE_VOICE, 7'd0, 7'd0, 3'd0);
      send_item(CMD_SPARE_LO, 7'd127, 7'd127, 3'd7);
      send_item(CMD_SPARE_HI, 7'd0, 7'd1, 3'd0);
      send_item(CMD_ALL_NOTES_OFF, 7'd0, 7'd0, 3'd0);
      send_item(CMD_ALL_SOUND_OFF, 7'd0, 7'd0, 3'd0);

      settle();
      write_register(CSR_MODEL_LOADED, 1'b1);
      write_register(CSR_MUTATION_ON, 1'b1);

      // Fill all eight voices, with note 0 held twice and the note extremes.
      send_item(CMD_NOTE_ON, 7'd0, 7'd127, 3'd0);
      send_item(CMD_NOTE_ON, 7'd127, 7'd1, 3'd0);
      send_item(CMD_NOTE_ON, 7'd0, 7'd64, 3'd0);
      for (int n = 10; n < 15; n++)
         send_item(CMD_NOTE_ON, 7'(n), 7'(n * 8), 3'(n));
      // The note-off must pick the older of the two voices playing note 0.
      send_item(CMD_NOTE_OFF, 7'd0, 7'd0, 3'd0);
      // Table full: first the releasing voice is stolen, then the oldest held one.
      send_item(CMD_NOTE_ON, 7'd33, 7'd90, 3'd0);
      send_item(CMD_NOTE_ON, 7'd34, 7'd90, 3'd0);
      // Zero velocity acts as a note-off.
      send_item(CMD_NOTE_ON, 7'd12, 7'd0, 3'd0);
      // Retire works on a releasing voice only.
      send_item(CMD_RETIRE_VOICE, 7'd0, 7'd0, 3'd5);
      send_item(CMD_RETIRE_VOICE, 7'd0, 7'd0, 3'd7);
      send_item(CMD_ALL_NOTES_OFF, 7'd0, 7'd0, 3'd0);
      send_item(CMD_RETIRE_VOICE, 7'd0, 7'd0, 3'd7);
      send_item(CMD_NOTE_ON, 7'd90, 7'd100, 3'd0);
      // Clears all voices; the age stamps keep counting afterwards.
      send_item(CMD_ALL_SOUND_OFF, 7'd0, 7'd0, 3'd0);

      run_phase(1'b1, 1'b0, 400, 1'b0, 1'b1, 1'b0);
      run_phase(1'b1, 1'b1, 400, 1'b1, 1'b0, 1'b0);
      run_phase(1'b0, 1'b1, 150, 1'b0, 1'b0, 1'b0);
      run_phase(1'b1, 1'b0, 400, 1'b0, 1'b0, 1'b1);
      run_phase(1'b1, 1'b1, 650, 1'b0, 1'b1, 1'b0);

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fault_count == 0 && results_pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
